>>> src/pac_pkg.sv
// shared constants, types and tables of the pointing angle calculator
package pac_pkg;

    // field widths
    localparam int COORD_W  = 24;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int ANGLE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int IN_W     = 6 * COORD_W + 2 * ANGLE_W;
    localparam int OUT_W    = 2 * ANGLE_W;

    // cordic datapath
    localparam int CORDIC_ITER_DEF = 16;
    localparam int ATAN_LEN        = 24;
    localparam int PRESCALE        = 7;
    localparam int CW              = 35;
    localparam int ZW              = 27;

    // square root datapath
    localparam int SQ_W       = 2 * DELTA_W;
    localparam int RAD_W      = 64;
    localparam int RAD_SHIFT  = 14;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;

    // pipeline bookkeeping
    localparam int FRONT_STAGES = 3;
    localparam int TAIL_STAGES  = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;
    localparam logic signed [ZW-1:0] Z_HALF_TURN = 27'sd11796480;

    typedef struct packed {
        logic dx_zero;
        logic dy_zero;
        logic dz_zero;
        logic dx_pos;
        logic dy_pos;
        logic dz_pos;
    } t_flags;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] cur_p;
        logic signed [ANGLE_W-1:0] cur_y;
        logic signed [DELTA_W-1:0] dz;
        t_flags                    flags;
    } t_side;

    // atan(2^-i) in degrees * 2^16
    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                0:       v = 27'sd2949120;
                1:       v = 27'sd1740967;
                2:       v = 27'sd919879;
                3:       v = 27'sd466945;
                4:       v = 27'sd234379;
                5:       v = 27'sd117304;
                6:       v = 27'sd58666;
                7:       v = 27'sd29335;
                8:       v = 27'sd14668;
                9:       v = 27'sd7334;
                10:      v = 27'sd3667;
                11:      v = 27'sd1833;
                12:      v = 27'sd917;
                13:      v = 27'sd458;
                14:      v = 27'sd229;
                15:      v = 27'sd115;
                16:      v = 27'sd57;
                17:      v = 27'sd29;
                18:      v = 27'sd14;
                19:      v = 27'sd7;
                20:      v = 27'sd4;
                21:      v = 27'sd2;
                22:      v = 27'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> src/pointing_angle_calculator.sv
// top level of the pointing angle calculator: cell chains, valid tracking, output buffer
//
//  channel   | dir | handshake                       | payload
//  ----------+-----+---------------------------------+------------------------------------
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | from_x/y/z, to_x/y/z, current angles
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | new_pitch, new_yaw
//  cfg       | in  | i_cfg_we                        | smoothing_gain
//
//  one request is taken per cycle; each result passes the front stages, the 32-cell
//  square root chain and then the pitch cordic chain and the tail before it leaves
//  (the yaw cordic runs beside the square root)
//  the whole chain moves together; it halts only while both output slots are full,
//  so one finished result can wait at the port while requests keep flowing
//  synchronous active-low reset clears valid bits, output buffer and gain (to 1.0)
module pointing_angle_calculator #(
    parameter int CORDIC_ITERATIONS = pac_pkg::CORDIC_ITER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z, current_pitch, current_yaw
    input  logic [pac_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // new_pitch, new_yaw
    output logic [pac_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [pac_pkg::GAIN_W-1:0]    i_cfg_wdata
);
    import pac_pkg::*;

    localparam int PIPE_LEN = FRONT_STAGES + SQRT_STEPS + CORDIC_ITERATIONS + TAIL_STAGES;
    localparam logic [1:0] OUT_SLOTS = 2'd2;

    // chain enable and request tracking
    logic                w_en;
    logic [PIPE_LEN-1:0] r_vld;

    // gain register
    logic [GAIN_W-1:0] r_gain;

    // field unpack
    logic signed [COORD_W-1:0] w_from_x, w_from_y, w_from_z, w_to_x, w_to_y, w_to_z;
    logic signed [ANGLE_W-1:0] w_cur_p, w_cur_y;

    // square root chain with yaw lane alongside
    logic        [REM_W-1:0]  w_rem  [0:SQRT_STEPS];
    logic        [ROOT_W-1:0] w_root [0:SQRT_STEPS];
    logic        [RAD_W-1:0]  w_rad  [0:SQRT_STEPS];
    t_side                    w_side_s [0:SQRT_STEPS];
    logic signed [CW-1:0]     w_yx [0:SQRT_STEPS];
    logic signed [CW-1:0]     w_yy [0:SQRT_STEPS];
    logic signed [ZW-1:0]     w_yz [0:SQRT_STEPS];

    // pitch cordic chain
    logic signed [CW-1:0]     w_px [0:CORDIC_ITERATIONS];
    logic signed [CW-1:0]     w_py [0:CORDIC_ITERATIONS];
    logic signed [ZW-1:0]     w_pz [0:CORDIC_ITERATIONS];
    t_side                    w_side_c [0:CORDIC_ITERATIONS];
    logic signed [ZW-1:0]     w_yz_c [0:CORDIC_ITERATIONS];

    // results and output buffer
    logic signed [ANGLE_W-1:0] w_new_p, w_new_y;
    logic                      w_push, w_pop;
    logic [OUT_W-1:0]          r_fifo [0:1];
    logic                      r_wptr, r_rptr;
    logic [1:0]                r_cnt, n_cnt;

    // chain advances whenever there is room for what reaches the end
    assign w_en            = (r_cnt != OUT_SLOTS);
    assign o_s_axis_tready = w_en;

    assign w_from_x = i_s_axis_tdata[0*COORD_W +: COORD_W];
    assign w_from_y = i_s_axis_tdata[1*COORD_W +: COORD_W];
    assign w_from_z = i_s_axis_tdata[2*COORD_W +: COORD_W];
    assign w_to_x   = i_s_axis_tdata[3*COORD_W +: COORD_W];
    assign w_to_y   = i_s_axis_tdata[4*COORD_W +: COORD_W];
    assign w_to_z   = i_s_axis_tdata[5*COORD_W +: COORD_W];
    assign w_cur_p  = i_s_axis_tdata[6*COORD_W +: ANGLE_W];
    assign w_cur_y  = i_s_axis_tdata[6*COORD_W+ANGLE_W +: ANGLE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // valid bits shift with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_s_axis_tvalid};
        end
    end

    pac_front u_front (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_from_x        (w_from_x),
        .i_from_y        (w_from_y),
        .i_from_z        (w_from_z),
        .i_to_x          (w_to_x),
        .i_to_y          (w_to_y),
        .i_to_z          (w_to_z),
        .i_current_pitch (w_cur_p),
        .i_current_yaw   (w_cur_y),
        .o_rad           (w_rad[0]),
        .o_side          (w_side_s[0]),
        .o_yx            (w_yx[0]),
        .o_yy            (w_yy[0]),
        .o_yz            (w_yz[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    // one root digit per cell; the first cells also run the yaw rotations
    for (genvar gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
        t_side r_side;

        pac_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rem[gk]),
            .i_root (w_root[gk]),
            .i_rad  (w_rad[gk]),
            .o_rem  (w_rem[gk+1]),
            .o_root (w_root[gk+1]),
            .o_rad  (w_rad[gk+1])
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side <= w_side_s[gk];
            end
        end
        assign w_side_s[gk+1] = r_side;

        if (gk < CORDIC_ITERATIONS) begin : g_yaw
            pac_cordic_cell #(.P_IDX(gk)) u_yaw (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_x   (w_yx[gk]),
                .i_y   (w_yy[gk]),
                .i_z   (w_yz[gk]),
                .o_x   (w_yx[gk+1]),
                .o_y   (w_yy[gk+1]),
                .o_z   (w_yz[gk+1])
            );
        end else begin : g_yaw_hold
            logic signed [CW-1:0] r_x, r_y;
            logic signed [ZW-1:0] r_z;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_x <= w_yx[gk];
                    r_y <= w_yy[gk];
                    r_z <= w_yz[gk];
                end
            end
            assign w_yx[gk+1] = r_x;
            assign w_yy[gk+1] = r_y;
            assign w_yz[gk+1] = r_z;
        end
    end

    // pitch vector: horizontal length against scaled dz
    assign w_px[0]     = {{(CW-ROOT_W){1'b0}}, w_root[SQRT_STEPS]};
    assign w_py[0]     = {{(CW-DELTA_W-PRESCALE){w_side_s[SQRT_STEPS].dz[DELTA_W-1]}},
                          w_side_s[SQRT_STEPS].dz, PRESCALE'(0)};
    assign w_pz[0]     = '0;
    assign w_side_c[0] = w_side_s[SQRT_STEPS];
    assign w_yz_c[0]   = w_yz[SQRT_STEPS];

    for (genvar gc = 0; gc < CORDIC_ITERATIONS; gc++) begin : g_pitch
        t_side                r_side;
        logic signed [ZW-1:0] r_yaw_z;

        pac_cordic_cell #(.P_IDX(gc)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_px[gc]),
            .i_y   (w_py[gc]),
            .i_z   (w_pz[gc]),
            .o_x   (w_px[gc+1]),
            .o_y   (w_py[gc+1]),
            .o_z   (w_pz[gc+1])
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side  <= w_side_c[gc];
                r_yaw_z <= w_yz_c[gc];
            end
        end
        assign w_side_c[gc+1] = r_side;
        assign w_yz_c[gc+1]   = r_yaw_z;
    end

    pac_tail u_tail (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_gain      (r_gain),
        .i_side      (w_side_c[CORDIC_ITERATIONS]),
        .i_yaw_z     (w_yz_c[CORDIC_ITERATIONS]),
        .i_pitch_z   (w_pz[CORDIC_ITERATIONS]),
        .o_new_pitch (w_new_p),
        .o_new_yaw   (w_new_y)
    );

    // two-slot output buffer
    assign w_push = w_en && r_vld[PIPE_LEN-1];
    assign w_pop  = o_m_axis_tvalid && i_m_axis_tready;
    assign n_cnt  = r_cnt + 2'(w_push) - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wptr] <= {w_new_y, w_new_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= r_wptr ^ w_push;
            r_rptr <= r_rptr ^ w_pop;
            r_cnt  <= n_cnt;
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_fifo[r_rptr];

endmodule

>>> src/pac_front.sv
// delta vector, squares, radicand and yaw cordic pre-rotation
module pac_front (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_from_x,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_from_y,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_from_z,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_to_x,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_to_y,
    input  logic signed [pac_pkg::COORD_W-1:0]   i_to_z,
    input  logic signed [pac_pkg::ANGLE_W-1:0]   i_current_pitch,
    input  logic signed [pac_pkg::ANGLE_W-1:0]   i_current_yaw,
    output logic        [pac_pkg::RAD_W-1:0]     o_rad,
    output pac_pkg::t_side                       o_side,
    output logic signed [pac_pkg::CW-1:0]        o_yx,
    output logic signed [pac_pkg::CW-1:0]        o_yy,
    output logic signed [pac_pkg::ZW-1:0]        o_yz
);
    import pac_pkg::*;

    // stage 0: deltas
    logic signed [DELTA_W-1:0] r_dx, r_dy, r_dz;
    logic signed [ANGLE_W-1:0] r_cur_p, r_cur_y;

    // stage 1: squares and yaw start point
    logic        [DELTA_W-1:0] w_ax, w_ay;
    logic        [SQ_W-1:0]    r_sqx, r_sqy;
    t_side                     n_side1, r_side1;
    logic signed [CW-1:0]      w_x0, w_y0, n_yx, n_yy, r_yx1, r_yy1;
    logic signed [ZW-1:0]      n_yz, r_yz1;

    // stage 2: radicand
    logic        [SQ_W-1:0]    w_sum;
    logic        [RAD_W-1:0]   r_rad;
    t_side                     r_side2;
    logic signed [CW-1:0]      r_yx2, r_yy2;
    logic signed [ZW-1:0]      r_yz2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= {i_to_x[COORD_W-1], i_to_x} - {i_from_x[COORD_W-1], i_from_x};
            r_dy    <= {i_to_y[COORD_W-1], i_to_y} - {i_from_y[COORD_W-1], i_from_y};
            r_dz    <= {i_to_z[COORD_W-1], i_to_z} - {i_from_z[COORD_W-1], i_from_z};
            r_cur_p <= i_current_pitch;
            r_cur_y <= i_current_yaw;
        end
    end

    assign w_ax = r_dx[DELTA_W-1] ? (DELTA_W'(0) - r_dx) : r_dx;
    assign w_ay = r_dy[DELTA_W-1] ? (DELTA_W'(0) - r_dy) : r_dy;

    // scaled by 2^7 before the cordic
    assign w_x0 = {{(CW-DELTA_W-PRESCALE){r_dx[DELTA_W-1]}}, r_dx, PRESCALE'(0)};
    assign w_y0 = {{(CW-DELTA_W-PRESCALE){r_dy[DELTA_W-1]}}, r_dy, PRESCALE'(0)};

    always_comb begin
        n_side1.cur_p         = r_cur_p;
        n_side1.cur_y         = r_cur_y;
        n_side1.dz            = r_dz;
        n_side1.flags.dx_zero = (r_dx == '0);
        n_side1.flags.dy_zero = (r_dy == '0);
        n_side1.flags.dz_zero = (r_dz == '0);
        n_side1.flags.dx_pos  = !r_dx[DELTA_W-1];
        n_side1.flags.dy_pos  = !r_dy[DELTA_W-1];
        n_side1.flags.dz_pos  = !r_dz[DELTA_W-1];
        // left half plane: rotate by a half turn first
        if (r_dx[DELTA_W-1]) begin
            n_yx = CW'(0) - w_x0;
            n_yy = CW'(0) - w_y0;
            n_yz = r_dy[DELTA_W-1] ? (ZW'(0) - Z_HALF_TURN) : Z_HALF_TURN;
        end else begin
            n_yx = w_x0;
            n_yy = w_y0;
            n_yz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx   <= SQ_W'(w_ax) * SQ_W'(w_ax);
            r_sqy   <= SQ_W'(w_ay) * SQ_W'(w_ay);
            r_side1 <= n_side1;
            r_yx1   <= n_yx;
            r_yy1   <= n_yy;
            r_yz1   <= n_yz;
        end
    end

    assign w_sum = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad   <= {w_sum, RAD_SHIFT'(0)};
            r_side2 <= r_side1;
            r_yx2   <= r_yx1;
            r_yy2   <= r_yy1;
            r_yz2   <= r_yz1;
        end
    end

    assign o_rad  = r_rad;
    assign o_side = r_side2;
    assign o_yx   = r_yx2;
    assign o_yy   = r_yy2;
    assign o_yz   = r_yz2;

endmodule

>>> src/pac_sqrt_cell.sv
// one root digit of the pipelined integer square root
module pac_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pac_pkg::REM_W-1:0]     i_rem,
    input  logic [pac_pkg::ROOT_W-1:0]    i_root,
    input  logic [pac_pkg::RAD_W-1:0]     i_rad,
    output logic [pac_pkg::REM_W-1:0]     o_rem,
    output logic [pac_pkg::ROOT_W-1:0]    o_root,
    output logic [pac_pkg::RAD_W-1:0]     o_rad
);
    import pac_pkg::*;

    logic [REM_W-1:0]  w_shift, w_trial, n_rem, r_rem;
    logic [ROOT_W-1:0] n_root, r_root;
    logic [RAD_W-1:0]  n_rad, r_rad;
    logic              w_fit;

    // bring down the next two radicand bits
    assign w_shift = {i_rem[REM_W-3:0], i_rad[RAD_W-1 -: 2]};
    assign w_trial = {{(REM_W-ROOT_W-2){1'b0}}, i_root, 2'b01};
    assign w_fit   = (w_shift >= w_trial);
    assign n_rem   = w_fit ? (w_shift - w_trial) : w_shift;
    assign n_root  = {i_root[ROOT_W-2:0], w_fit};
    assign n_rad   = {i_rad[RAD_W-3:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

>>> src/pac_cordic_cell.sv
// one vectoring micro-rotation of the cordic chain
module pac_cordic_cell #(
    parameter int P_IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [pac_pkg::CW-1:0] i_x,
    input  logic signed [pac_pkg::CW-1:0] i_y,
    input  logic signed [pac_pkg::ZW-1:0] i_z,
    output logic signed [pac_pkg::CW-1:0] o_x,
    output logic signed [pac_pkg::CW-1:0] o_y,
    output logic signed [pac_pkg::ZW-1:0] o_z
);
    import pac_pkg::*;

    logic signed [CW-1:0] w_xs, w_ys, n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0] n_z, r_z;

    assign w_xs = i_x >>> P_IDX;
    assign w_ys = i_y >>> P_IDX;

    always_comb begin
        if (!i_y[CW-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + atan_step(P_IDX);
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - atan_step(P_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

>>> src/pac_tail.sv
// angle conversion, special cases and smoothing blend
module pac_tail (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic        [pac_pkg::GAIN_W-1:0]   i_gain,
    input  pac_pkg::t_side                      i_side,
    input  logic signed [pac_pkg::ZW-1:0]       i_yaw_z,
    input  logic signed [pac_pkg::ZW-1:0]       i_pitch_z,
    output logic signed [pac_pkg::ANGLE_W-1:0]  o_new_pitch,
    output logic signed [pac_pkg::ANGLE_W-1:0]  o_new_yaw
);
    import pac_pkg::*;

    localparam int QW    = ZW - 9;
    localparam int SAT_W = 20;
    localparam int DW    = ANGLE_W + 1;
    localparam int PW    = 2 * DW;
    localparam int SHW   = PW - 15;
    localparam logic signed [ZW-1:0]    Q97_RND  = ZW'(256);
    localparam logic signed [PW-1:0]    PROD_RND = PW'(16384);
    localparam logic signed [SAT_W-1:0] LIM_180  = SAT_W'(23040);
    localparam logic signed [SAT_W-1:0] LIM_89   = SAT_W'(11392);
    localparam logic signed [ANGLE_W-1:0] A_180  = ANGLE_W'(23040);
    localparam logic signed [ANGLE_W-1:0] A_90   = ANGLE_W'(11520);
    localparam logic signed [ANGLE_W-1:0] A_89   = ANGLE_W'(11392);

    function automatic logic signed [ANGLE_W-1:0] sat(
        input logic signed [SAT_W-1:0] v,
        input logic signed [SAT_W-1:0] lim
    );
        logic signed [SAT_W-1:0] r;
        begin
            r = v;
            if (v > lim) begin
                r = lim;
            end else if (v < -lim) begin
                r = -lim;
            end
            return r[ANGLE_W-1:0];
        end
    endfunction

    // stage t0: target angles
    logic signed [ZW-1:0]      w_yrnd, w_prnd;
    logic signed [QW-1:0]      w_yq, w_pq;
    logic signed [SAT_W-1:0]   w_yq_x, w_pneg;
    logic signed [ANGLE_W-1:0] n_tgt_p, n_tgt_y, r_tgt_p, r_tgt_y, r_cur_p0, r_cur_y0;

    // stage t1: blend products
    logic signed [DW-1:0]      w_dp, w_dy, w_gs;
    logic signed [PW-1:0]      r_prod_p, r_prod_y;
    logic signed [ANGLE_W-1:0] r_cur_p1, r_cur_y1;

    // output side
    logic signed [PW-1:0]      w_rp, w_ry;
    logic signed [SHW-1:0]     w_shp, w_shy;
    logic signed [SAT_W-1:0]   w_bp, w_by;

    // degrees * 2^16 to q9.7 with round half up
    assign w_yrnd = i_yaw_z + Q97_RND;
    assign w_prnd = i_pitch_z + Q97_RND;
    assign w_yq   = w_yrnd[ZW-1:9];
    assign w_pq   = w_prnd[ZW-1:9];
    assign w_yq_x = {{(SAT_W-QW){w_yq[QW-1]}}, w_yq};
    assign w_pneg = SAT_W'(0) - {{(SAT_W-QW){w_pq[QW-1]}}, w_pq};

    always_comb begin
        if (i_side.flags.dx_zero && i_side.flags.dy_zero) begin
            n_tgt_y = '0;
        end else if (i_side.flags.dy_zero) begin
            n_tgt_y = i_side.flags.dx_pos ? ANGLE_W'(0) : A_180;
        end else if (i_side.flags.dx_zero) begin
            n_tgt_y = i_side.flags.dy_pos ? A_90 : (ANGLE_W'(0) - A_90);
        end else begin
            n_tgt_y = sat(w_yq_x, LIM_180);
        end

        if (i_side.flags.dz_zero) begin
            n_tgt_p = '0;
        end else if (i_side.flags.dx_zero && i_side.flags.dy_zero) begin
            // straight up or down clamps at the limit
            n_tgt_p = i_side.flags.dz_pos ? (ANGLE_W'(0) - A_89) : A_89;
        end else begin
            n_tgt_p = sat(w_pneg, LIM_89);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tgt_p  <= n_tgt_p;
            r_tgt_y  <= n_tgt_y;
            r_cur_p0 <= i_side.cur_p;
            r_cur_y0 <= i_side.cur_y;
        end
    end

    assign w_dp = {r_tgt_p[ANGLE_W-1], r_tgt_p} - {r_cur_p0[ANGLE_W-1], r_cur_p0};
    assign w_dy = {r_tgt_y[ANGLE_W-1], r_tgt_y} - {r_cur_y0[ANGLE_W-1], r_cur_y0};
    assign w_gs = {1'b0, i_gain};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_p <= PW'(w_dp) * PW'(w_gs);
            r_prod_y <= PW'(w_dy) * PW'(w_gs);
            r_cur_p1 <= r_cur_p0;
            r_cur_y1 <= r_cur_y0;
        end
    end

    assign w_rp  = r_prod_p + PROD_RND;
    assign w_ry  = r_prod_y + PROD_RND;
    assign w_shp = w_rp[PW-1:15];
    assign w_shy = w_ry[PW-1:15];
    assign w_bp  = {{(SAT_W-ANGLE_W){r_cur_p1[ANGLE_W-1]}}, r_cur_p1}
                 + {{(SAT_W-SHW){w_shp[SHW-1]}}, w_shp};
    assign w_by  = {{(SAT_W-ANGLE_W){r_cur_y1[ANGLE_W-1]}}, r_cur_y1}
                 + {{(SAT_W-SHW){w_shy[SHW-1]}}, w_shy};

    assign o_new_pitch = sat(w_bp, LIM_180);
    assign o_new_yaw   = sat(w_by, LIM_180);

endmodule

>>> src/pac_checker.sv
// port-level checks for the pointing angle calculator and its bind
module pac_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_axis_tready,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [pac_pkg::OUT_W-1:0]  o_m_axis_tdata
);
    import pac_pkg::*;

    localparam logic signed [ANGLE_W-1:0] LIM = ANGLE_W'(23040);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("held result changed or vanished");

    // reset empties the output side and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not empty after reset");

    // input only blocks while results are backed up
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input blocked with no result pending");

    // blocked input stays blocked until a result is taken
    a_block_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready && !i_m_axis_tready |=> !o_s_axis_tready)
        else $error("input opened without draining a result");

    // smoothed angles stay within a half turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[ANGLE_W-1:0]) <= LIM) &&
            ($signed(o_m_axis_tdata[ANGLE_W-1:0]) >= -LIM) &&
            ($signed(o_m_axis_tdata[OUT_W-1:ANGLE_W]) <= LIM) &&
            ($signed(o_m_axis_tdata[OUT_W-1:ANGLE_W]) >= -LIM))
        else $error("result angle out of range");

endmodule

bind pointing_angle_calculator pac_checker u_pac_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
